>>> rtl/gaussian_blur_5x5_stream_assert.svh
// Assertion macros for the 5x5 Gaussian blur stream.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef GAUSSIAN_BLUR_5X5_STREAM_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_STREAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GB5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Trigger in one cycle implies consequence in the next, disabled during reset.
`define GB5_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/gb5_pkg.sv
// Shared types and constants of the 5x5 Gaussian blur stream.
// No dependencies.
package gb5_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned KSIZE      = 5;
  localparam int unsigned MEM_ROWS   = 4;
  localparam int unsigned NCLS       = 6;
  localparam int unsigned CLS_W      = 11;
  localparam int unsigned PROD_W     = CLS_W + COEF_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned PIX_MAX    = 255;
  localparam int unsigned ROW_MODE_W = 3;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST4   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST5   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIST8   = 3'd7;

  // Distance classes (squared tap distance 0,1,2,4,5,8)
  localparam int unsigned CLS_D0 = 0;
  localparam int unsigned CLS_D1 = 1;
  localparam int unsigned CLS_D2 = 2;
  localparam int unsigned CLS_D4 = 3;
  localparam int unsigned CLS_D5 = 4;
  localparam int unsigned CLS_D8 = 5;

  // Row selection modes applied to a fetched column
  localparam logic [ROW_MODE_W-1:0] ROW_RAW  = 3'd0;
  localparam logic [ROW_MODE_W-1:0] ROW_TOP2 = 3'd1;
  localparam logic [ROW_MODE_W-1:0] ROW_TOP3 = 3'd2;
  localparam logic [ROW_MODE_W-1:0] ROW_BOT1 = 3'd3;
  localparam logic [ROW_MODE_W-1:0] ROW_BOT2 = 3'd4;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             last_of_frame;
  } pix_out_t;

  // One window column, index 0 is the top row
  typedef logic [KSIZE-1:0][PIX_W-1:0] col_t;
  // Last five fetched columns, index 0 is the newest
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] hist_t;
  typedef logic [NCLS-1:0][COEF_W-1:0] coef_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic left0;
    logic left1;
    logic right1;
    logic right0;
  } win_ctl_t;

  localparam logic [ROW_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RST = 13'd480;
  localparam coef_t COEF_RST = {16'd194, 16'd872, 16'd1437, 16'd3908, 16'd6443, 16'd10623};

endpackage

>>> rtl/gb5_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module gb5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gb5_filter.sv
// Weighted-sum datapath: window select, class sums, products, final sum and output register.
// Depends on gb5_pkg.
module gb5_filter import gb5_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  win_ctl_t ctl_i,
  input  hist_t    hist_i,
  input  coef_t    coef_i,
  output logic     valid_o,
  output pix_out_t data_o
);

  hist_t                        win;
  logic [NCLS-1:0][CLS_W-1:0]   cls_d, cls_q;
  logic [NCLS-1:0][PROD_W-1:0]  prod_d, prod_q;
  logic                         v3_q, last3_q, v4_q, last4_q, v5_q;
  logic [SUM_W-1:0]             sum_d, shr;
  pix_out_t                     res_d, res_q;

  // pick history columns; columns beyond the frame edge repeat the edge column
  always_comb begin
    win[2] = hist_i[2];
    win[0] = ctl_i.left0 ? hist_i[2] : (ctl_i.left1 ? hist_i[3] : hist_i[4]);
    win[1] = ctl_i.left0 ? hist_i[2] : hist_i[3];
    win[3] = ctl_i.right0 ? hist_i[2] : hist_i[1];
    win[4] = ctl_i.right0 ? hist_i[2] : (ctl_i.right1 ? hist_i[1] : hist_i[0]);
  end

  // sum the pixels that share one weight
  always_comb begin
    cls_d[CLS_D0] = CLS_W'(win[2][2]);
    cls_d[CLS_D1] = CLS_W'(win[1][2]) + CLS_W'(win[3][2]) + CLS_W'(win[2][1])
                  + CLS_W'(win[2][3]);
    cls_d[CLS_D2] = CLS_W'(win[1][1]) + CLS_W'(win[1][3]) + CLS_W'(win[3][1])
                  + CLS_W'(win[3][3]);
    cls_d[CLS_D4] = CLS_W'(win[0][2]) + CLS_W'(win[4][2]) + CLS_W'(win[2][0])
                  + CLS_W'(win[2][4]);
    cls_d[CLS_D5] = CLS_W'(win[0][1]) + CLS_W'(win[0][3]) + CLS_W'(win[4][1])
                  + CLS_W'(win[4][3]) + CLS_W'(win[1][0]) + CLS_W'(win[3][0])
                  + CLS_W'(win[1][4]) + CLS_W'(win[3][4]);
    cls_d[CLS_D8] = CLS_W'(win[0][0]) + CLS_W'(win[0][4]) + CLS_W'(win[4][0])
                  + CLS_W'(win[4][4]);
  end

  always_comb begin
    for (int k = 0; k < NCLS; k++) begin
      prod_d[k] = PROD_W'(cls_q[k]) * PROD_W'(coef_i[k]);
    end
  end

  always_comb begin
    sum_d = SUM_W'(prod_q[CLS_D0]) + SUM_W'(prod_q[CLS_D1]) + SUM_W'(prod_q[CLS_D2])
          + SUM_W'(prod_q[CLS_D4]) + SUM_W'(prod_q[CLS_D5]) + SUM_W'(prod_q[CLS_D8]);
    shr   = sum_d >> COEF_FRAC_BITS;
    res_d.blurred       = (shr > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : shr[PIX_W-1:0];
    res_d.last_of_frame = last4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= ctl_i.emit;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cls_q   <= cls_d;
      last3_q <= ctl_i.last;
      prod_q  <= prod_d;
      last4_q <= last3_q;
      res_q   <= res_d;
    end
  end

  assign valid_o = v5_q;
  assign data_o  = res_q;

endmodule

>>> rtl/gaussian_blur_5x5_stream.sv
// 5x5 Gaussian blur on a raster stream of 8-bit gray pixels, border pixels replicated.
// Throughput: one item per cycle; the whole pipe holds only while a result waits at the output.
// Pipeline: line store read, column history, class sums, products and output register;
// in pixel terms a result lags the input by two rows and two pixels, drain items flush the rest.
// Reset: counters cleared, registers to their defaults; the line store is not cleared,
// the first two rows of a frame are covered by edge replication. Depends on gb5_pkg.
`include "gaussian_blur_5x5_stream_assert.svh"

module gaussian_blur_5x5_stream import gb5_pkg::*; #(
  parameter int unsigned MAX_WIDTH      = 4096,
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pix_out_t             out_data_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WORD_W = MEM_ROWS * PIX_W;

  typedef struct packed {
    logic                  is_pix;
    logic [PIX_W-1:0]      pixel;
    logic [ROW_MODE_W-1:0] mode;
  } s1_t;

  // ---------------------------------------------------------------- config
  logic [ROW_W-1:0] width_q, height_q;
  coef_t            coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      coef_q   <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q        <= cfg_data_i[ROW_W-1:0];
        CFG_IMAGE_HEIGHT: height_q       <= cfg_data_i[ROW_W-1:0];
        CFG_COEF_DIST0:   coef_q[CLS_D0] <= cfg_data_i;
        CFG_COEF_DIST1:   coef_q[CLS_D1] <= cfg_data_i;
        CFG_COEF_DIST2:   coef_q[CLS_D2] <= cfg_data_i;
        CFG_COEF_DIST4:   coef_q[CLS_D4] <= cfg_data_i;
        CFG_COEF_DIST5:   coef_q[CLS_D5] <= cfg_data_i;
        CFG_COEF_DIST8:   coef_q[CLS_D8] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the frame size into the supported range
  logic [COL_W-1:0] w_eff, w_m1, w_m2;
  logic [ROW_W-1:0] h_eff, h_m1;

  always_comb begin
    if (width_q < ROW_W'(KSIZE)) begin
      w_eff = COL_W'(KSIZE);
    end else if ({1'b0, width_q} > (ROW_W + 1)'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(width_q);
    end
    if (height_q < ROW_W'(KSIZE)) begin
      h_eff = ROW_W'(KSIZE);
    end else if (height_q > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    w_m1 = w_eff - COL_W'(1);
    w_m2 = w_eff - COL_W'(2);
    h_m1 = h_eff - ROW_W'(1);
  end

  // ---------------------------------------------------------------- intake
  // The whole pipe advances together whenever the output register is free or
  // being emptied; a waiting result therefore blocks new beats only while
  // the sink holds it off.
  logic     adv, in_acc;
  logic     res_valid;
  pix_out_t res_data;

  assign adv        = !res_valid || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && in_ready_o;

  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             in_done_q, in_done_d;

  logic                  s0_is_pix, s0_fetch, s0_emit, s0_last, s0_pos_ok;
  logic [COL_W-1:0]      in_col_inc, out_col_inc;
  logic [ROW_W-1:0]      in_row_inc, out_row_inc;
  logic [ROW_MODE_W-1:0] s0_mode;
  win_ctl_t              s0_ctl;

  always_comb begin
    s0_is_pix = (in_data_i.cmd == CMD_PIXEL);
    // pixels are taken until the frame is in, drain beats only after that
    s0_fetch  = s0_is_pix ? !in_done_q : in_done_q;
    s0_pos_ok = (in_row_q > ROW_W'(2)) || (in_row_q == ROW_W'(2) && in_col_q >= COL_W'(2));
    s0_emit   = s0_fetch && (!s0_is_pix || s0_pos_ok);
    s0_last   = !s0_is_pix && in_done_q &&
                ((out_row_q > h_m1) || (out_row_q == h_m1 && out_col_q >= w_m1));

    // rows above the frame repeat row 0; rows below repeat the bottom row
    if (in_done_q) begin
      s0_mode = (in_row_q == h_eff) ? ROW_BOT1 : ROW_BOT2;
    end else if (in_row_q == ROW_W'(2)) begin
      s0_mode = ROW_TOP2;
    end else if (in_row_q == ROW_W'(3)) begin
      s0_mode = ROW_TOP3;
    end else begin
      s0_mode = ROW_RAW;
    end

    s0_ctl.emit   = s0_emit;
    s0_ctl.last   = s0_last;
    s0_ctl.left0  = (out_col_q == '0);
    s0_ctl.left1  = (out_col_q == COL_W'(1));
    s0_ctl.right1 = (out_col_q == w_m2);
    s0_ctl.right0 = (out_col_q == w_m1);
  end

  always_comb begin
    in_col_inc  = in_col_q + COL_W'(1);
    in_row_inc  = in_row_q + ROW_W'(1);
    out_col_inc = out_col_q + COL_W'(1);
    out_row_inc = out_row_q + ROW_W'(1);
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    in_done_d   = in_done_q;
    // drain beats keep walking the fetch position past the bottom row
    if (in_acc && s0_fetch) begin
      if (in_col_inc >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_inc;
        if (s0_is_pix && in_row_inc >= h_eff) begin
          in_done_d = 1'b1;
        end
      end else begin
        in_col_d = in_col_inc;
      end
    end
    if (in_acc && s0_emit) begin
      if (out_col_inc >= w_eff) begin
        out_col_d = '0;
        out_row_d = out_row_inc;
      end else begin
        out_col_d = out_col_inc;
      end
    end
    // final output of the frame: start over
    if (in_acc && s0_last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      in_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_done_q <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      in_done_q <= in_done_d;
    end
  end

  // ---------------------------------------------------------------- line store
  // One word per column holds the four rows above the current input row,
  // oldest in the low byte. Each pixel beat reads its column, then writes it
  // back shifted with the new pixel on top when the beat advances out of stage 1.
  logic                                ram_we, ram_re;
  logic [ADDR_W-1:0]                   ram_waddr, ram_raddr;
  logic [MEM_ROWS-1:0][PIX_W-1:0]      ram_rdata, ram_wdata;

  logic              s1_v_q;
  s1_t               s1_q;
  logic [ADDR_W-1:0] s1_addr_q;
  win_ctl_t          s1_ctl_q;

  assign ram_re    = in_acc && s0_fetch;
  assign ram_raddr = in_col_q[ADDR_W-1:0];
  assign ram_we    = adv && s1_v_q && s1_q.is_pix;
  assign ram_waddr = s1_addr_q;
  assign ram_wdata = {s1_q.pixel, ram_rdata[3], ram_rdata[2], ram_rdata[1]};

  gb5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.is_pix <= s0_is_pix;
      s1_q.pixel  <= in_data_i.pixel;
      s1_q.mode   <= s0_mode;
      s1_addr_q   <= ram_raddr;
      s1_ctl_q    <= s0_ctl;
    end
  end

  // ---------------------------------------------------------------- column history
  col_t     s1_col;
  hist_t    hist_q;
  logic     s2_v_q;
  win_ctl_t s2_ctl_q, s2_ctl;

  always_comb begin
    case (s1_q.mode)
      ROW_TOP2: s1_col = {s1_q.pixel, ram_rdata[3], ram_rdata[2], ram_rdata[2], ram_rdata[2]};
      ROW_TOP3: s1_col = {s1_q.pixel, ram_rdata[3], ram_rdata[2], ram_rdata[1], ram_rdata[1]};
      ROW_BOT1: s1_col = {ram_rdata[3], ram_rdata[3], ram_rdata[2], ram_rdata[1], ram_rdata[0]};
      ROW_BOT2: s1_col = {ram_rdata[3], ram_rdata[3], ram_rdata[3], ram_rdata[2], ram_rdata[1]};
      default:  s1_col = {s1_q.pixel, ram_rdata[3], ram_rdata[2], ram_rdata[1], ram_rdata[0]};
    endcase
  end

  // advance the history by one column per fetch; idle beats leave it alone
  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      hist_q <= {hist_q[KSIZE-2:0], s1_col};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_comb begin
    s2_ctl      = s2_ctl_q;
    s2_ctl.emit = s2_v_q && s2_ctl_q.emit;
  end

  // ---------------------------------------------------------------- datapath
  gb5_filter #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (s2_ctl),
    .hist_i  (hist_q),
    .coef_i  (coef_q),
    .valid_o (res_valid),
    .data_o  (res_data)
  );

  assign out_valid_o = res_valid;
  assign out_data_o  = res_data;

  // ---------------------------------------------------------------- checks
  `GB5_ASSERT(a_no_rw_clash, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "line store read and write hit one column")
  `GB5_ASSERT_NEXT(a_last_restarts, (in_acc && s0_last), (in_row_q == '0 && in_col_q == '0 && out_row_q == '0 && !in_done_q), "frame end did not clear the counters")
  `GB5_ASSERT(a_done_on_pixel, $rose(in_done_q) |-> $past(in_acc && s0_is_pix), "frame end flagged without a pixel beat")
  `GB5_ASSERT(a_drain_no_write, (s1_v_q && (s1_q.mode == ROW_BOT1 || s1_q.mode == ROW_BOT2)) |-> !s1_q.is_pix, "drain fetch would write the line store")

endmodule

>>> tb/tb_gaussian_blur_5x5_stream.sv
// Self-checking testbench for the 5x5 Gaussian blur stream (gaussian_blur_5x5_stream).
// Drives whole frames through the valid/ready pixel port and scores every output beat
// against an in-bench predictor. Depends on gb5_pkg and the block RTL.
module tb_gaussian_blur_5x5_stream;
  import gb5_pkg::*;

  // Geometry and fixed-point format of the instance under test
  localparam int unsigned LINE_MAX  = 4096;
  localparam int unsigned ROWS_MAX  = 4096;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned FILL_MARK = 100;
  localparam logic [12:0] WIDTH_DEFAULT  = 13'd640;
  localparam logic [12:0] HEIGHT_DEFAULT = 13'd480;
  // Weights by distance class, class 0 (centre) in the low slot
  localparam logic [5:0][15:0] WEIGHT_DEFAULT =
    {16'd194, 16'd872, 16'd1437, 16'd3908, 16'd6443, 16'd10623};

  typedef enum int unsigned {
    WS_RANDOM, WS_ALL_MAX, WS_ZERO, WS_MODEST, WS_DEFAULT, WS_ONE_TAP
  } weight_set_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pix_out_t             out_data;

  // Beats waiting to be offered, and blurred pixels waiting to come out
  pix_in_t     pix_pending_q[$];
  pix_out_t    blur_expect_q[$];

  logic        in_beat = 1'b0;     // the offered beat was taken at the last rising edge
  int unsigned src_gap = 0;
  int unsigned snk_hold = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          long_hold_done = 1'b0;
  bit          tail_run = 1'b0;
  int unsigned beats_out = 0;
  int unsigned mismatches = 0;

  // Predictor state: five line slots, configuration copy and raster counters
  logic [7:0]  line_mem [5][LINE_MAX];
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [15:0] weight_reg [6];
  int unsigned row_in, col_in, row_out, col_out;
  bit          input_done;

  gaussian_blur_5x5_stream #(
    .MAX_WIDTH      (LINE_MAX),
    .COEF_FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Width and height as used: clamped into 5..max
  function automatic int unsigned active_width();
    if (width_reg < 5) return 5;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 5) return 5;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return 32'(height_reg);
  endfunction

  function automatic int pin(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Weight of a tap by its squared distance from the centre
  function automatic logic [15:0] tap_weight(input int unsigned dist_sq);
    case (dist_sq)
      0:       return weight_reg[CLS_D0];
      1:       return weight_reg[CLS_D1];
      2:       return weight_reg[CLS_D2];
      4:       return weight_reg[CLS_D4];
      5:       return weight_reg[CLS_D5];
      default: return weight_reg[CLS_D8];
    endcase
  endfunction

  // Blur the window centred on the next output position, then advance that position
  function automatic logic [7:0] next_blurred(input int unsigned w, input int unsigned h);
    int          r, c, rr, cc, dy, dx;
    logic [31:0] acc;
    r = (row_out > ROWS_MAX) ? ROWS_MAX : row_out;
    c = (col_out > LINE_MAX) ? LINE_MAX : col_out;
    acc = '0;
    for (dy = -2; dy <= 2; dy++) begin
      rr = pin(r + dy, int'(h) - 1);
      for (dx = -2; dx <= 2; dx++) begin
        cc = pin(c + dx, int'(w) - 1);
        acc += 32'(line_mem[rr % 5][cc]) * 32'(tap_weight(dy * dy + dx * dx));
      end
    end
    acc = acc >> FRAC;
    if (acc > 32'd255) acc = 32'd255;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      if (row_out <= ROWS_MAX) row_out++;
    end
    return acc[7:0];
  endfunction

  // Apply one accepted input beat; returns 1 when it yields a blurred pixel
  function automatic bit blur_step(input pix_in_t item, output pix_out_t res);
    int unsigned     w, h, r, c;
    longint unsigned pos;
    bit              fire, last;
    w = active_width();
    h = active_height();
    res = '0;
    if (item.cmd == CMD_PIXEL) begin
      // drop pixels that arrive while the frame is draining
      if (input_done) return 1'b0;
      r = (row_in > ROWS_MAX) ? ROWS_MAX : row_in;
      c = (col_in >= w) ? w - 1 : col_in;
      line_mem[r % 5][c] = item.pixel;
      pos = longint'(row_in) * w + col_in;
      fire = (pos >= 2 * longint'(w) + 2);
      if (fire) res.blurred = next_blurred(w, h);
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
        if (row_in >= h) input_done = 1'b1;
      end
      return fire;
    end
    // drain before the frame is complete: nothing to flush
    if (!input_done) return 1'b0;
    last = (row_out > h - 1) || (row_out == h - 1 && col_out >= w - 1);
    res.blurred = next_blurred(w, h);
    res.last_of_frame = last;
    if (last) begin
      row_in = 0;
      col_in = 0;
      row_out = 0;
      col_out = 0;
      input_done = 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: register writes, output check, prediction of accepted beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score_p
    pix_out_t want;
    pix_out_t got;
    in_beat <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data[ROW_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
          CFG_COEF_DIST0:   weight_reg[CLS_D0] = cfg_data;
          CFG_COEF_DIST1:   weight_reg[CLS_D1] = cfg_data;
          CFG_COEF_DIST2:   weight_reg[CLS_D2] = cfg_data;
          CFG_COEF_DIST4:   weight_reg[CLS_D4] = cfg_data;
          CFG_COEF_DIST5:   weight_reg[CLS_D5] = cfg_data;
          default:          weight_reg[CLS_D8] = cfg_data;
        endcase
      end
      // Retire the output beat first: it can never stem from a beat taken at this edge
      if (out_valid && out_ready) begin
        got = out_data;
        beats_out++;
        if (blur_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got blurred %0d last %0b",
                   $time, got.blurred, got.last_of_frame);
        end else begin
          want = blur_expect_q.pop_front();
          if (got.blurred !== want.blurred) begin
            mismatches++;
            $display("%0t: blurred mismatch, expected %0d, got %0d",
                     $time, want.blurred, got.blurred);
          end
          if (got.last_of_frame !== want.last_of_frame) begin
            mismatches++;
            $display("%0t: last_of_frame mismatch, expected %0b, got %0b",
                     $time, want.last_of_frame, got.last_of_frame);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (blur_step(in_data, want)) blur_expect_q = {blur_expect_q, want};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: offer queued beats at the falling edge, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
      // hold the beat and its payload until it is taken
    end else if (src_gap != 0) begin
      in_valid <= 1'b0;
      src_gap  <= src_gap - 1;
    end else if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      src_gap  <= $urandom_range(5, 0);
    end else if (pix_pending_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= pix_pending_q.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output sink: random stall bursts, plus one long hold-off once the run is
  // under way and plenty of beats are queued, so the pipe backs up to its input
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (snk_hold != 0) begin
      out_ready <= 1'b0;
      snk_hold  <= snk_hold - 1;
    end else if (!long_hold_done && !tail_run && beats_out >= FILL_MARK &&
                 pix_pending_q.size() > 40) begin
      out_ready      <= 1'b0;
      snk_hold       <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (snk_idle_pct != 0 && $urandom_range(99, 0) < snk_idle_pct) begin
      out_ready <= 1'b0;
      snk_hold  <= $urandom_range(5, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic queue_item(input logic cmd, input logic [7:0] px);
    pix_in_t item;
    item.cmd   = cmd;
    item.pixel = px;
    pix_pending_q = {pix_pending_q, item};
  endtask

  // Wait until every queued beat is taken and every blurred pixel has come out
  task automatic wait_quiet();
    do @(posedge clk);
    while (pix_pending_q.size() != 0 || in_valid || blur_expect_q.size() != 0);
  endtask

  // Let the pipe empty of beats that give no result before touching registers
  task automatic settle();
    repeat (8) @(posedge clk);
  endtask

  // Register code for a size: below-range and above-range codes clamp to the
  // same size, and the bits above the 13-bit field must be ignored
  function automatic logic [CFG_W-1:0] size_code(input int unsigned eff);
    int unsigned v;
    v = eff;
    if (eff == 5 && $urandom_range(1, 0) == 1) v = $urandom_range(4, 0);
    if (eff == ROWS_MAX && $urandom_range(1, 0) == 1) v = $urandom_range(8191, ROWS_MAX + 1);
    return {3'($urandom_range(7, 0)), 13'(v)};
  endfunction

  task automatic load_weights(input weight_set_e set);
    logic [CFG_IDX_W-1:0] regs [6];
    logic [CFG_W-1:0]     val;
    int unsigned          k, lone;
    regs = '{CFG_COEF_DIST0, CFG_COEF_DIST1, CFG_COEF_DIST2,
             CFG_COEF_DIST4, CFG_COEF_DIST5, CFG_COEF_DIST8};
    lone = $urandom_range(5, 0);
    for (k = 0; k < 6; k++) begin
      case (set)
        WS_RANDOM:  val = 16'($urandom_range(65535, 0));
        WS_ALL_MAX: val = 16'hFFFF;
        WS_ZERO:    val = '0;
        WS_MODEST:  val = 16'($urandom_range(4000, 0));
        WS_DEFAULT: val = WEIGHT_DEFAULT[k];
        default:    val = (k == lone) ? 16'($urandom_range(65535, 0)) : '0;
      endcase
      write_reg(regs[k], val);
    end
  endtask

  function automatic int unsigned idle_choice();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // Queue one whole frame: w*h pixels then the drains that flush the last
  // 2w+2 outputs. Stray drains go among the pixels and stray pixels among the
  // drains; the block must drop both. Optionally pause halfway until quiet.
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned noise_pct, input bit pause_mid);
    int unsigned n, kind;
    logic [7:0]  px;
    @(posedge clk);
    kind = $urandom_range(3, 0);
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(99, 0) < noise_pct) queue_item(CMD_DRAIN, 8'($urandom_range(255, 0)));
      case (kind)
        0:       px = 8'($urandom_range(255, 0));
        1:       px = $urandom_range(1, 0) ? 8'hFF : 8'h00;
        2:       px = 8'hFF;
        default: px = 8'((n * 37) ^ (n >> 3));
      endcase
      queue_item(CMD_PIXEL, px);
      if (pause_mid && n == (w * h) / 2) wait_quiet();
    end
    for (n = 0; n < 2 * w + 2; n++) begin
      if ($urandom_range(99, 0) < noise_pct) queue_item(CMD_PIXEL, 8'($urandom_range(255, 0)));
      queue_item(CMD_DRAIN, 8'($urandom_range(255, 0)));
    end
    // a drain once the frame is closed is dropped as well
    if ($urandom_range(99, 0) < noise_pct) queue_item(CMD_DRAIN, 8'h00);
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h,
                           input int unsigned noise_pct, input bit pause_mid);
    write_reg(CFG_IMAGE_WIDTH, size_code(w));
    write_reg(CFG_IMAGE_HEIGHT, size_code(h));
    queue_frame(w, h, noise_pct, pause_mid);
    wait_quiet();
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned fw, fh, frames, budget, n;
    width_reg  = WIDTH_DEFAULT;
    height_reg = HEIGHT_DEFAULT;
    for (n = 0; n < 6; n++) weight_reg[n] = WEIGHT_DEFAULT[n];
    row_in = 0;
    col_in = 0;
    row_out = 0;
    col_out = 0;
    input_done = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // Directed frame on the reset weights: smallest size, checkerboard of the
    // pixel extremes, and every drop case (drain too early, pixel while
    // draining, drain after the frame is closed)
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd5);
    @(posedge clk);
    queue_item(CMD_DRAIN, 8'hFF);
    for (n = 0; n < 25; n++) begin
      queue_item(CMD_PIXEL, (n == 12) ? 8'h7F : (((n / 5 + n % 5) % 2) ? 8'hFF : 8'h00));
      if (n == 10) queue_item(CMD_DRAIN, 8'h00);
    end
    queue_item(CMD_DRAIN, 8'h00);
    queue_item(CMD_PIXEL, 8'hAA);
    for (n = 0; n < 11; n++) queue_item(CMD_DRAIN, 8'h55);
    queue_item(CMD_DRAIN, 8'h00);
    wait_quiet();
    settle();

    // Random frames, mostly small, each on a fresh weight set and idle mix
    budget = 0;
    frames = 0;
    while (budget < 420) begin
      load_weights(weight_set_e'(frames % 6));
      fw = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 5);
      fh = $urandom_range(8, 5);
      src_idle_pct = idle_choice();
      snk_idle_pct = idle_choice();
      run_frame(fw, fh, 6, frames == 1);
      budget += fw * fh + 2 * fw + 2;
      frames++;
    end

    // Closing stretch at full rate on both sides
    tail_run = 1'b1;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (n = 0; n < 2; n++) begin
      load_weights(WS_MODEST);
      run_frame($urandom_range(12, 5), $urandom_range(8, 5), 4, 1'b0);
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_gaussian_blur_5x5_stream: clean");
    end else begin
      $display("tb_gaussian_blur_5x5_stream: errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #2000000;
    $display("tb_gaussian_blur_5x5_stream: errors");
    $finish;
  end

endmodule
